>>> hdl/lurl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurl_pkg
// Shared constants and types for the longest unique run length block.
// ----------------------------------------------------------------------------
package lurl_pkg;

  localparam int unsigned LenBitsDef = 16;
  localparam int unsigned SymBits    = 8;
  localparam int unsigned NumSyms    = 1 << SymBits;
  localparam int unsigned FieldBits  = 16;

  // Read and write requests from the window logic to the position table.
  typedef struct packed {
    logic               rd_en;
    logic [SymBits-1:0] rd_addr;
    logic               wr_en;
    logic [SymBits-1:0] wr_addr;
  } mem_ctl_t;

endpackage

>>> hdl/lurl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurl_if
// Valid/ready channels for the string bytes and the run length results.
// ----------------------------------------------------------------------------
interface lurl_in_if;
  logic                        valid;
  logic                        ready;
  logic [lurl_pkg::SymBits-1:0] byte_value;
  logic                        last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface lurl_out_if;
  logic                          valid;
  logic                          ready;
  logic [lurl_pkg::FieldBits-1:0] best_length;
  logic [lurl_pkg::FieldBits-1:0] window_length;
  logic                          string_done;

  modport source (output valid, output best_length, output window_length,
                  output string_done, input ready);
  modport sink   (input valid, input best_length, input window_length,
                  input string_done, output ready);
endinterface

>>> hdl/lurl_pos_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurl_pos_mem
// Last-seen position table: one synchronous read and one write per cycle,
// with the write of the same edge forwarded to the read result.
// ----------------------------------------------------------------------------
module lurl_pos_mem #(
  parameter int unsigned LenBits = lurl_pkg::LenBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lurl_pkg::mem_ctl_t   ctl_i,
  input  logic [LenBits-1:0]   wr_data_i,
  output logic [LenBits-1:0]   rd_data_o
);

  logic [LenBits-1:0]           mem_q [lurl_pkg::NumSyms];
  logic [LenBits-1:0]           rd_q;
  logic [lurl_pkg::SymBits-1:0] rd_addr_q;
  logic [lurl_pkg::SymBits-1:0] fwd_addr_q;
  logic [LenBits-1:0]           fwd_data_q;
  logic                         fwd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q      <= mem_q[ctl_i.rd_addr];
      rd_addr_q <= ctl_i.rd_addr;
    end
  end

  // Keep the most recent write; it covers a write that landed on the read edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (ctl_i.wr_en) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      fwd_addr_q <= ctl_i.wr_addr;
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = (fwd_vld_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : rd_q;

endmodule

>>> hdl/lurl_window_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurl_window_ctl
// Sliding window update: seen bits, position, window start, best length and
// the output register.
// ----------------------------------------------------------------------------
module lurl_window_ctl #(
  parameter int unsigned LenBits = lurl_pkg::LenBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lurl_in_if.sink            req_i,
  lurl_out_if.source         rsp_o,
  output lurl_pkg::mem_ctl_t mem_ctl_o,
  output logic [LenBits-1:0] mem_wr_data_o,
  input  logic [LenBits-1:0] mem_rd_data_i
);

  localparam int unsigned FieldBits = lurl_pkg::FieldBits;

  logic                         s1_vld_q;
  logic [lurl_pkg::SymBits-1:0] s1_byte_q;
  logic                         s1_last_q;
  logic [LenBits-1:0]           pos_q, start_q, best_q;
  logic [lurl_pkg::NumSyms-1:0] seen_q;
  logic                         out_vld_q;
  logic [FieldBits-1:0]         out_best_q, out_wl_q;
  logic                         out_done_q;

  logic               out_free, s1_adv, acc, hit;
  logic [LenBits-1:0] span, gap, start_d, wl_raw, wl_d, best_d;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign s1_adv      = s1_vld_q && out_free;
  assign req_i.ready = !s1_vld_q || s1_adv;
  assign acc         = req_i.valid && req_i.ready;

  assign mem_ctl_o.rd_en   = acc;
  assign mem_ctl_o.rd_addr = req_i.byte_value;
  assign mem_ctl_o.wr_en   = s1_adv;
  assign mem_ctl_o.wr_addr = s1_byte_q;
  assign mem_wr_data_o     = pos_q;

  // Earlier occurrence inside [start, pos-1] moves the start past it.
  always_comb begin
    span    = pos_q - start_q;
    gap     = pos_q - mem_rd_data_i;
    hit     = seen_q[s1_byte_q] && (gap != '0) && ((gap - 1'b1) < span);
    start_d = hit ? (mem_rd_data_i + 1'b1) : start_q;
    wl_raw  = pos_q - start_d;
    wl_d    = (&wl_raw) ? wl_raw : (wl_raw + 1'b1);
    best_d  = (wl_d > best_q) ? wl_d : best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
      start_q   <= '0;
      best_q    <= '0;
      seen_q    <= '0;
    end else begin
      s1_vld_q  <= acc || (s1_vld_q && !s1_adv);
      out_vld_q <= s1_adv || (out_vld_q && !rsp_o.ready);
      if (s1_adv) begin
        if (s1_last_q) begin
          // End of string: drop all per-string state.
          pos_q   <= '0;
          start_q <= '0;
          best_q  <= '0;
          seen_q  <= '0;
        end else begin
          pos_q             <= pos_q + 1'b1;
          start_q           <= start_d;
          best_q            <= best_d;
          seen_q[s1_byte_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_byte_q <= req_i.byte_value;
      s1_last_q <= req_i.last_byte;
    end
    if (s1_adv) begin
      out_best_q <= FieldBits'(best_d);
      out_wl_q   <= FieldBits'(wl_d);
      out_done_q <= s1_last_q;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.best_length   = out_best_q;
  assign rsp_o.window_length = out_wl_q;
  assign rsp_o.string_done   = out_done_q;

endmodule

>>> hdl/longest_unique_run_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_unique_run_length
// Streaming longest repeat-free run over byte strings.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one byte per request, last_byte marks the end of a string.
//   rsp_o returns one result per byte: the length of the repeat-free window
//   ending at that byte, the best length so far in the string, and
//   string_done on the result of the last byte, where best_length is final.
//   Throughput is one byte per cycle while rsp_o.ready is high; the loop is
//   one read of the last-position table, issued at acceptance, and one
//   write-back as the byte leaves lookup, forwarded to a same-entry read.
//   Each byte passes the lookup stage and then the output register, which
//   holds its result on rsp_o until it is taken.
//   Reset clears the seen bits, position, window start and best length in
//   flip-flops at once; no clearing pass runs. The same happens after each
//   last byte, so the next byte starts a new string without a gap.
//   When the receiver stalls, the result waits in the output register; one
//   more byte enters the lookup stage if it is empty, then req_i.ready drops.
//   Lengths saturate at 2^LenBits - 1; positions wrap modulo 2^LenBits.
// ----------------------------------------------------------------------------
module longest_unique_run_length #(
  parameter int unsigned LenBits = lurl_pkg::LenBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lurl_in_if.sink     req_i,
  lurl_out_if.source  rsp_o
);

  lurl_pkg::mem_ctl_t mem_ctl;
  logic [LenBits-1:0] mem_wr_data;
  logic [LenBits-1:0] mem_rd_data;

  lurl_window_ctl #(
    .LenBits (LenBits)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .mem_ctl_o     (mem_ctl),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data)
  );

  lurl_pos_mem #(
    .LenBits (LenBits)
  ) u_pos_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

endmodule

>>> hdl/lurl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurl_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lurl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [lurl_pkg::FieldBits-1:0] best_length_i,
  input logic [lurl_pkg::FieldBits-1:0] window_length_i,
  input logic                           string_done_i
);

  logic                           first_q;
  logic [lurl_pkg::FieldBits-1:0] prev_best_q;

  // Track whether the next result opens a string and the best length before it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      prev_best_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      first_q     <= string_done_i;
      prev_best_q <= best_length_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(best_length_i)
      && $stable(window_length_i) && $stable(string_done_i))
    else $error("result dropped or changed while stalled");

  a_window_le_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> window_length_i <= best_length_i)
    else $error("window length exceeds best length");

  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && first_q |-> window_length_i == 1 && best_length_i == 1)
    else $error("first byte of a string does not give length one");

  a_best_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !first_q |-> best_length_i >= prev_best_q)
    else $error("best length fell within a string");

endmodule

bind longest_unique_run_length lurl_checker u_lurl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .best_length_i   (rsp_o.best_length),
  .window_length_i (rsp_o.window_length),
  .string_done_i   (rsp_o.string_done)
);
